/* rtl/prs80_pkg.sv */
package prs80_pkg;

   localparam int unsigned BlockWidth = 64;
   localparam int unsigned KeyWidth   = 80;
   localparam int unsigned KeyHighWidth = 16;
   localparam int unsigned RoundWidth = 5;
   localparam int unsigned NumRounds  = 31;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH = 2'd1;

   typedef logic [BlockWidth-1:0] block_type;
   typedef logic [KeyWidth-1:0]   key_type;
   typedef logic [RoundWidth-1:0] round_type;

   typedef struct packed {
      block_type state;
      key_type   key;
   } stage_type;

   function automatic logic [3:0] sbox(input logic [3:0] x);
      logic [3:0] y;
      unique case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         default: y = 4'h2;
      endcase
      return y;
   endfunction

   function automatic block_type sbox_layer(input block_type s);
      block_type r;
      for (int n = 0; n < BlockWidth / 4; n++) begin
         r[4*n +: 4] = sbox(s[4*n +: 4]);
      end
      return r;
   endfunction

   function automatic block_type perm_layer(input block_type s);
      block_type r;
      for (int j = 0; j < BlockWidth; j++) begin
         r[(BlockWidth / 4) * (j % 4) + (j / 4)] = s[j];
      end
      return r;
   endfunction

   function automatic block_type round_key(input key_type k);
      return k[KeyWidth-1 -: BlockWidth];
   endfunction

   function automatic key_type key_update(input key_type k, input round_type rnd);
      key_type n;
      n = {k[18:0], k[KeyWidth-1:19]};
      n[KeyWidth-1 -: 4] = sbox(n[KeyWidth-1 -: 4]);
      n[19:15] = n[19:15] ^ rnd;
      return n;
   endfunction

endpackage

/* rtl/prs80_round.sv */
module prs80_round (
   input  logic                 clock,
   input  logic                 reset,
   input  prs80_pkg::round_type round_num,
   input  logic                 valid_in,
   input  prs80_pkg::stage_type stage_in,
   output logic                 valid_out,
   output prs80_pkg::stage_type stage_out
);
   import prs80_pkg::*;

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_nxt_in;

   always_comb begin
      stage_nxt_in.state = perm_layer(sbox_layer(stage_in.state ^ round_key(stage_in.key)));
      stage_nxt_in.key   = key_update(stage_in.key, round_num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_nxt_in;
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

/* rtl/present80_block_encrypt.sv */
// An accepted start beat passes the round registers, then rsp_strobe_ff.
// Throughput: one block per cycle; one pipeline register per round, 31 rounds
// plus a registered final key addition.
// busy stays low: the pipeline never stalls since the receiver cannot stall.
// Reset (synchronous, active high) clears the key registers and all valid bits.
module present80_block_encrypt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  prs80_pkg::block_type                req_plaintext,
   output logic                                rsp_strobe,
   output prs80_pkg::block_type                rsp_ciphertext,
   input  logic                                csr_we,
   input  logic [prs80_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [prs80_pkg::BlockWidth-1:0]    csr_wdata
);
   import prs80_pkg::*;

   logic [BlockWidth-1:0]   key_low_ff;
   logic [KeyHighWidth-1:0] key_high_ff;

   logic      stage_valid [NumRounds+1];
   stage_type stage_data  [NumRounds+1];

   logic      rsp_strobe_ff;
   block_type rsp_ciphertext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[KeyHighWidth-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   assign stage_valid[0]      = start;
   assign stage_data[0].state = req_plaintext;
   assign stage_data[0].key   = {key_high_ff, key_low_ff};

   for (genvar i = 0; i < NumRounds; i++) begin : g_round
      prs80_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_num (RoundWidth'(i + 1)),
         .valid_in  (stage_valid[i]),
         .stage_in  (stage_data[i]),
         .valid_out (stage_valid[i+1]),
         .stage_out (stage_data[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_valid[NumRounds];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ciphertext_ff <= stage_data[NumRounds].state ^ round_key(stage_data[NumRounds].key);
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      start |=> stage_valid[1])
      else $error("start beat did not enter the first round stage");

   a_last_to_strobe: assert property (@(posedge clock) disable iff (reset)
      stage_valid[NumRounds] |=> rsp_strobe)
      else $error("last round beat did not reach rsp_strobe");

   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, NumRounds + 1))
      else $error("rsp_strobe without a start beat 32 cycles earlier");

endmodule

/* verif/present80_block_encrypt_tb.sv */
module present80_block_encrypt_tb;
   import prs80_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_BLOCKS = 100;
   localparam logic [CsrIndexWidth-1:0] CSR_RSVD_2 = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RSVD_3 = 2'd3;
   localparam logic [63:0] SBOX_TABLE = 64'h2174_8FE3_DA09_B65C;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   block_type req_plaintext = '0;
   logic rsp_strobe;
   block_type rsp_ciphertext;
   logic csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_KEY_LOW;
   logic [BlockWidth-1:0] csr_wdata = '0;

   block_type plain_queue[$];
   block_type cipher_due[$];
   logic [63:0] key_lo;
   logic [15:0] key_hi;
   int unsigned idle_pct = 0;
   int unsigned idle_run = 0;
   bit any_fail = 1'b0;

   present80_block_encrypt dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_plaintext(req_plaintext),
      .rsp_strobe(rsp_strobe),
      .rsp_ciphertext(rsp_ciphertext),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [3:0] sub_nibble(input logic [3:0] x);
      return SBOX_TABLE[4*x +: 4];
   endfunction

   function automatic block_type present_encrypt(input block_type pt, input logic [79:0] key);
      block_type s;
      block_type t;
      logic [79:0] k;
      s = pt;
      k = key;
      for (int r = 1; r <= NumRounds; r++) begin
         s = s ^ k[79:16];
         for (int n = 0; n < 16; n++) t[4*n +: 4] = sub_nibble(s[4*n +: 4]);
         for (int j = 0; j < 64; j++) s[16*(j % 4) + j / 4] = t[j];
         k = {k[18:0], k[79:19]};
         k[79:76] = sub_nibble(k[79:76]);
         k[19:15] = k[19:15] ^ 5'(r);
      end
      return s ^ k[79:16];
   endfunction

   function automatic block_type random_block();
      block_type b;
      int unsigned pick;
      pick = $urandom_range(9);
      b = {$urandom, $urandom};
      case (pick)
         0: b = 64'h1 << $urandom_range(63);
         1: b = ~(64'h1 << $urandom_range(63));
         2: b = {16{b[3:0]}};
         default: ;
      endcase
      return b;
   endfunction

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx, input block_type data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic csr_close();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (plain_queue.size() != 0 || start || cipher_due.size() != 0);
   endtask

   // driver: hold a presented beat until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (plain_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_plaintext <= plain_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: key shadow, prediction, check, watchdog
   always @(posedge clock) begin
      block_type want;
      if (reset) begin
         key_lo = '0;
         key_hi = '0;
         idle_run = 0;
      end else begin
         if (rsp_strobe) begin
            if (cipher_due.size() == 0) begin
               $error("ciphertext: no beat expected, got %h", rsp_ciphertext);
               any_fail = 1'b1;
            end else begin
               want = cipher_due.pop_front();
               if (rsp_ciphertext !== want) begin
                  $error("ciphertext: expected %h, got %h", want, rsp_ciphertext);
                  any_fail = 1'b1;
               end
            end
         end
         if (start && !busy) cipher_due.push_back(present_encrypt(req_plaintext, {key_hi, key_lo}));
         if (csr_we) begin
            if (csr_index == CSR_KEY_LOW) key_lo = csr_wdata;
            else if (csr_index == CSR_KEY_HIGH) key_hi = csr_wdata[15:0];
         end
         if ((start && !busy) || rsp_strobe || csr_we) idle_run = 0;
         else idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int unsigned idle_plan[8];
      idle_plan = '{0, 79, 14, 0, 79, 14, 79, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset key, edge patterns
      plain_queue.push_back(64'h0);
      plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      plain_queue.push_back(64'h0123_4567_89AB_CDEF);
      plain_queue.push_back(64'hFEDC_BA98_7654_3210);
      plain_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      plain_queue.push_back(64'h5555_5555_5555_5555);
      plain_queue.push_back(64'h0000_0000_0000_0001);
      plain_queue.push_back(64'h8000_0000_0000_0000);
      plain_queue.push_back(64'h0000_0000_FFFF_FFFF);
      plain_queue.push_back(64'hFFFF_FFFF_0000_0000);
      plain_queue.push_back(64'h0F0F_0F0F_0F0F_0F0F);
      plain_queue.push_back(64'hF0F0_F0F0_F0F0_F0F0);
      wait_drained();

      // all-ones key; upper key_high bits and spare indexes must drop
      csr_write(CSR_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_RSVD_2, 64'h0);
      csr_write(CSR_RSVD_3, 64'h0);
      csr_close();
      plain_queue.push_back(64'h0);
      plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      plain_queue.push_back(64'h0123_4567_89AB_CDEF);
      wait_drained();

      csr_write(CSR_KEY_LOW, 64'h0);
      csr_write(CSR_KEY_HIGH, 64'hDEAD_BEEF_0000_8000);
      csr_close();
      plain_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      plain_queue.push_back(64'h0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            2: begin
               csr_write(CSR_KEY_LOW, 64'h0);
               csr_write(CSR_KEY_HIGH, 64'h0);
            end
            5: begin
               csr_write(CSR_KEY_HIGH, {$urandom, $urandom} | 64'hFFFF);
               csr_write(CSR_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            default: begin
               csr_write(CSR_KEY_LOW, {$urandom, $urandom});
               csr_write(CSR_KEY_HIGH, {$urandom, $urandom});
            end
         endcase
         if (p % 2 == 1) begin
            csr_write(CSR_RSVD_2, {$urandom, $urandom});
            csr_write(CSR_RSVD_3, {$urandom, $urandom});
         end
         csr_close();
         idle_pct = idle_plan[p];
         for (int i = 0; i < PHASE_BLOCKS; i++) plain_queue.push_back(random_block());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!any_fail && cipher_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/prs80_pkg.sv
rtl/prs80_round.sv
rtl/present80_block_encrypt.sv
verif/present80_block_encrypt_tb.sv
